@@ design/trial_division_prime_test_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the trial division prime test unit
// Clocked, reset-gated concurrent assertion forms.
// ---------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_ASSERT_SVH

// Plain property, sampled on clk, ignored while reset is asserted
`define TDPT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tdpt assertion failed");

// Antecedent implies consequent from the next cycle onward
`define TDPT_ASSERT_NEXT(label, ante, cons) \
	`TDPT_ASSERT(label, (ante) |=> (cons))

`endif

@@ design/tdpt_pkg.sv @@
// ---------------------------------------------------------------------------
// tdpt_pkg
// Shared widths and control structures for the prime test unit.
// ---------------------------------------------------------------------------
package tdpt_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int SQ_W        = VALUE_WIDTH + 1;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [SQ_W-1:0]        square_t;

	typedef struct packed {
		logic start;
	} rem_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

@@ design/tdpt_rem_unit.sv @@
// ---------------------------------------------------------------------------
// tdpt_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle, one
// subtract-and-compare shared over all steps.
// ---------------------------------------------------------------------------
module tdpt_rem_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  tdpt_pkg::rem_ctrl_t ctrl,
	input  tdpt_pkg::value_t    dividend,
	input  tdpt_pkg::value_t    divisor,
	output tdpt_pkg::rem_stat_t stat,
	output tdpt_pkg::value_t    remainder
);

	tdpt_pkg::value_t                 dividend_q;
	tdpt_pkg::value_t                 divisor_q;
	tdpt_pkg::value_t                 rem_q;
	logic [tdpt_pkg::CNT_W-1:0]       cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [tdpt_pkg::VALUE_WIDTH:0]   trial;
	logic [tdpt_pkg::VALUE_WIDTH:0]   diff;
	logic                             fits;
	logic                             last_step;

	assign trial = {rem_q, dividend_q[tdpt_pkg::VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = (trial >= {1'b0, divisor_q});

	assign last_step = busy_q && !ctrl.start &&
	                   (cnt_q == tdpt_pkg::CNT_W'(tdpt_pkg::VALUE_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + tdpt_pkg::CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dividend_q <= dividend;
			divisor_q  <= divisor;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= dividend_q << 1;
			rem_q      <= fits ? diff[tdpt_pkg::VALUE_WIDTH-1:0]
			                   : trial[tdpt_pkg::VALUE_WIDTH-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

@@ design/trial_division_prime_test_unit.sv @@
// ---------------------------------------------------------------------------
// trial_division_prime_test_unit
// Trial division primality test of one unsigned candidate per transfer.
// ---------------------------------------------------------------------------
// Input channel: candidate with in_valid / in_stall. A candidate is taken
// only while the unit is idle; in_stall stays high from the transfer until
// the answer has moved into the output register.
// Output channel: is_prime with out_valid / out_stall, one result per
// candidate, held in an output register for as long as out_stall is high.
// Divisors 2, 3, 4, ... are tried while the divisor squared does not exceed
// the candidate; the square is kept up to date by one add per divisor.
// Each divisor passes through a check step, a start step and the bit steps
// of the bit-serial remainder unit (one dividend bit per cycle).
// Candidates 0 and 1 go straight to the result; 2 and 3 need a single
// check step and no division.
// The next candidate can be taken in the cycle after the result is loaded.
// A stalled receiver holds a finished answer inside the unit until the
// output register is free.
// Reset (arst_n low) clears the sequencer and drops out_valid; no clearing
// pass is needed afterwards.
// ---------------------------------------------------------------------------
module trial_division_prime_test_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  tdpt_pkg::value_t candidate,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             is_prime,
	output logic             out_valid,
	input  logic             out_stall
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	state_t               state_q;
	tdpt_pkg::value_t     n_q;
	tdpt_pkg::value_t     d_q;
	tdpt_pkg::square_t    sq_q;
	logic                 prime_q;
	logic                 out_valid_q;
	logic                 is_prime_q;
	tdpt_pkg::rem_ctrl_t  rem_ctrl_q;
	tdpt_pkg::rem_stat_t  rem_stat;
	tdpt_pkg::value_t     remainder;
	logic                 past_root;
	logic                 out_load;

	tdpt_rem_unit u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (rem_ctrl_q),
		.dividend  (n_q),
		.divisor   (d_q),
		.stat      (rem_stat),
		.remainder (remainder)
	);

	// stop once the divisor squared passes the candidate
	assign past_root = (sq_q > {1'b0, n_q});
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			d_q         <= '0;
			sq_q        <= '0;
			prime_q     <= 1'b0;
			out_valid_q <= 1'b0;
			is_prime_q  <= 1'b0;
			rem_ctrl_q  <= '0;
		end else begin
			rem_ctrl_q.start <= (state_q == ST_CHECK) && !past_root;
			// hold a stalled result, drop it once transferred
			out_valid_q      <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q  <= candidate;
						d_q  <= tdpt_pkg::VALUE_WIDTH'(2);
						sq_q <= tdpt_pkg::SQ_W'(4);
						if (candidate < tdpt_pkg::VALUE_WIDTH'(2)) begin
							prime_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (past_root) begin
						prime_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (rem_stat.done) begin
						if (remainder == '0) begin
							prime_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							// (d+1)^2 = d^2 + 2d + 1
							sq_q    <= sq_q + {d_q, 1'b1};
							d_q     <= d_q + tdpt_pkg::VALUE_WIDTH'(1);
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						is_prime_q <= prime_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

endmodule

@@ design/tdpt_checker.sv @@
// ---------------------------------------------------------------------------
// tdpt_checker
// Port-level checks of the prime test unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "trial_division_prime_test_unit_assert.svh"

module tdpt_checker (
	input logic             clk,
	input logic             arst_n,
	input tdpt_pkg::value_t candidate,
	input logic             in_valid,
	input logic             in_stall,
	input logic             is_prime,
	input logic             out_valid,
	input logic             out_stall
);

	logic small_xfer;
	logic two_xfer;

	assign small_xfer = in_valid && !in_stall && !out_valid &&
	                    (candidate < tdpt_pkg::VALUE_WIDTH'(2));
	assign two_xfer   = in_valid && !in_stall && !out_valid &&
	                    (candidate == tdpt_pkg::VALUE_WIDTH'(2));

	// a stalled result holds
	`TDPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(is_prime))

	// one candidate at a time: busy right after a transfer
	`TDPT_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)

	// zero and one answer not prime
	`TDPT_ASSERT_NEXT(a_small_not_prime, small_xfer, ##1 (out_valid && !is_prime))

	// two answers prime
	`TDPT_ASSERT_NEXT(a_two_prime, two_xfer, ##2 (out_valid && is_prime))

endmodule

bind trial_division_prime_test_unit tdpt_checker u_tdpt_checker (.*);
